// ===== rtl/core/pure_pursuit_steering_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// pure pursuit steering controller assertion macros
// Same-cycle implication and next-cycle assertion helpers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_STEERING_CONTROLLER_UNIT_MACROS_SVH
`define PURE_PURSUIT_STEERING_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppsc assertion failed");
// next-cycle implication
`define PPSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppsc assertion failed");
`else
`define PPSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ppsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsc_pkg
// Shared types, constants and tables of the pure pursuit steering controller.
// ----------------------------------------------------------------------------
`default_nettype none
package ppsc_pkg;
	localparam int MAX_WAYPOINTS_DEF = 1024;

	// cordic and angle datapath widths
	localparam int CW = 56;
	localparam int ZW = 24;
	localparam int AW = 26;
	localparam int CORDIC_LAST = 15;
	localparam int SQRT_LAST = 31;
	localparam int DIV_LAST = 31;

	localparam logic signed [AW-1:0] ANG_PI = AW'(205887);
	localparam logic signed [AW-1:0] ANG_PI_2 = AW'(102944);
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(39797);

	// stream packing
	localparam int IN_TDATA_W = 216;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOKAHEAD   = 3'd0,
		REG_WHEEL_BASE  = 3'd1,
		REG_RATE        = 3'd2,
		REG_COUNT       = 3'd3,
		REG_KP          = 3'd4,
		REG_KD          = 3'd5,
		REG_STEER_LIMIT = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_L2, ST_WRD, ST_WDIF, ST_WSQA, ST_WSQB, ST_WCMP,
		ST_SRD, ST_SPD, ST_TRD, ST_TGT, ST_KP, ST_KD, ST_KR, ST_DIV, ST_VEL,
		ST_V1GO, ST_V1WT, ST_ALPHA, ST_DA, ST_DB, ST_DS, ST_SQWT,
		ST_SINGO, ST_SINWT, ST_WBS, ST_V2GO, ST_V2WT, ST_STEER, ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic rotate;
	} cor_cmd_t;

	// round(atan(2^-i) * 65536)
	function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
		logic signed [ZW-1:0] v;
		unique case (i)
			4'd0: v = ZW'(51472);
			4'd1: v = ZW'(30386);
			4'd2: v = ZW'(16055);
			4'd3: v = ZW'(8150);
			4'd4: v = ZW'(4091);
			4'd5: v = ZW'(2047);
			4'd6: v = ZW'(1024);
			4'd7: v = ZW'(512);
			4'd8: v = ZW'(256);
			4'd9: v = ZW'(128);
			4'd10: v = ZW'(64);
			4'd11: v = ZW'(32);
			4'd12: v = ZW'(16);
			4'd13: v = ZW'(8);
			4'd14: v = ZW'(4);
			default: v = ZW'(2);
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ppsc_cordic.sv =====
// ----------------------------------------------------------------------------
// ppsc_cordic
// Shared 16-step cordic, vectoring (atan) or rotation (sin), one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ppsc_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ppsc_pkg::cor_cmd_t                cmd,
	input  logic signed [ppsc_pkg::CW-1:0]    x0,
	input  logic signed [ppsc_pkg::CW-1:0]    y0,
	input  logic signed [ppsc_pkg::ZW-1:0]    z0,
	output logic signed [ppsc_pkg::CW-1:0]    y,
	output logic signed [ppsc_pkg::ZW-1:0]    z,
	output logic                              done
);
	import ppsc_pkg::*;

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, t;
	logic [3:0] cnt_q;
	logic busy_q, rot_q, done_q, up;

	// micro-rotation direction and shifted terms
	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		t  = atan_lut(cnt_q);
		up = rot_q ? (z_q < 0) : (y_q > 0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rot_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rot_q  <= cmd.rotate;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(CORDIC_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + t;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - t;
			end
		end
	end

	assign y = y_q;
	assign z = z_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/core/ppsc_isqrt.sv =====
// ----------------------------------------------------------------------------
// ppsc_isqrt
// Floor square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ppsc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);
	import ppsc_pkg::*;

	logic [63:0] n_q, res_q, bit_q, trial;
	logic [4:0] cnt_q;
	logic busy_q, done_q;

	assign trial = res_q + bit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SQRT_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// digit recurrence
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[31:0];
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/core/pure_pursuit_steering_controller_unit.sv =====
// ----------------------------------------------------------------------------
// pure_pursuit_steering_controller_unit
// Pure pursuit path tracker: waypoint table, speed law and steering law.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser selects load (write one waypoint) or step (pose in).
// A load gives no result. A step gives one result on m_*: velocity, steering,
// target index, and tuser set when the path end is hit. One multiplier and
// the memory read port serve the nearest and lookahead walks, then come a
// bit-serial divider, three 16-step cordic passes and a 32-step square root.
// A step at the path end goes straight to the finish state. s_tready is high
// only between items. A finished result waits in the output register while
// m_tready is low; the next item is accepted meanwhile, and a following step
// holds its result until the register is free. Configuration writes on
// cfg_* are never stalled, since cfg_ready is tied high.
// Reset clears configuration to defaults, the stored error and target; the
// waypoint table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pure_pursuit_steering_controller_unit_macros.svh"
module pure_pursuit_steering_controller_unit #(
	parameter int unsigned MAX_WAYPOINTS = ppsc_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// wp_index, wp_x, wp_y, wp_speed, pos_x, pos_y, speed, heading
	input  logic [ppsc_pkg::IN_TDATA_W-1:0]     s_tdata,
	// operation
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// velocity_cmd, steering_cmd, target_index
	output logic [ppsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// done_res
	output logic [0:0]                          m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ppsc_pkg::*;

	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

	// input fields
	logic [9:0] in_wp_index;
	logic signed [31:0] in_wp_x, in_wp_y, in_wp_speed, in_pos_x, in_pos_y;
	logic [30:0] in_speed;
	logic signed [14:0] in_heading;
	op_t in_op;

	assign in_wp_index = s_tdata[9:0];
	assign in_wp_x     = s_tdata[41:10];
	assign in_wp_y     = s_tdata[73:42];
	assign in_wp_speed = s_tdata[105:74];
	assign in_pos_x    = s_tdata[137:106];
	assign in_pos_y    = s_tdata[169:138];
	assign in_speed    = s_tdata[200:170];
	assign in_heading  = s_tdata[215:201];
	assign in_op       = op_t'(s_tuser[0]);

	// configuration registers
	logic [30:0] look_q, wb_q, kp_q, kd_q;
	logic [9:0] rate_q;
	logic [10:0] count_q;
	logic [12:0] lim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q  <= 31'd6554;
			wb_q    <= 31'd2621;
			rate_q  <= 10'd10;
			count_q <= 11'd0;
			kp_q    <= 31'd65536;
			kd_q    <= 31'd0;
			lim_q   <= 13'd2048;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOOKAHEAD:   look_q  <= cfg_data[30:0];
				REG_WHEEL_BASE:  wb_q    <= cfg_data[30:0];
				REG_RATE:        rate_q  <= cfg_data[9:0];
				REG_COUNT:       count_q <= cfg_data[10:0];
				REG_KP:          kp_q    <= cfg_data[30:0];
				REG_KD:          kd_q    <= cfg_data[30:0];
				REG_STEER_LIMIT: lim_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// state and registers
	state_t state_q, state_d;
	logic [IDX_W-1:0] addr_q, near_q, cur_tgt_q;
	logic [CNT_W-1:0] idx_q, cnt;
	logic walk2_q;
	logic signed [31:0] px_q, py_q, e_q, prev_err_q, vel_q;
	logic [30:0] spd_in_q;
	logic signed [14:0] head_q;
	logic [61:0] l2_q;
	logic [64:0] best_q;
	logic [32:0] ax_q, ay_q;
	logic [65:0] sqa_q, sqb_q;
	logic signed [32:0] dx_q, dy_q;
	logic big_q;
	logic signed [48:0] p1_q;
	logic [47:0] p3mag_q;
	logic de_neg_q;
	logic signed [59:0] t3_q;
	logic [31:0] dq_q;
	logic [9:0] rem_q;
	logic [4:0] div_cnt_q;
	logic signed [AW-1:0] alpha_q;
	logic [33:0] dist_q;
	logic [32:0] smag_q;
	logic s_neg_q;
	logic signed [50:0] num_q;
	logic signed [13:0] st_q;
	logic done_q;
	logic m_valid_q, res_done_q;
	logic signed [31:0] res_vel_q;
	logic signed [13:0] res_st_q;
	logic [9:0] res_tgt_q;

	// waypoint memories
	logic signed [31:0] mem_x [MAX_WAYPOINTS];
	logic signed [31:0] mem_y [MAX_WAYPOINTS];
	logic signed [31:0] mem_s [MAX_WAYPOINTS];
	logic signed [31:0] rd_x_q, rd_y_q, rd_s_q;
	logic [IDX_W-1:0] slot;
	logic load_acc;

	assign slot = IDX_W'(32'(in_wp_index) % MAX_WAYPOINTS);
	assign load_acc = s_tvalid && s_tready && (in_op == OP_LOAD);

	always_ff @(posedge clk) begin
		if (load_acc) begin
			mem_x[slot] <= in_wp_x;
			mem_y[slot] <= in_wp_y;
			mem_s[slot] <= in_wp_speed;
		end
		rd_x_q <= mem_x[addr_q];
		rd_y_q <= mem_y[addr_q];
		rd_s_q <= mem_s[addr_q];
	end

	// effective count and path end
	logic end_path;
	always_comb begin
		if (32'(count_q) > 32'(MAX_WAYPOINTS)) cnt = CNT_W'(MAX_WAYPOINTS);
		else cnt = CNT_W'(count_q);
		end_path = (cnt <= CNT_W'(1)) || (CNT_W'(cur_tgt_q) >= cnt - CNT_W'(1));
	end

	// waypoint differences
	logic signed [32:0] dxw, dyw;
	logic [32:0] axw, ayw;
	always_comb begin
		dxw = {rd_x_q[31], rd_x_q} - {px_q[31], px_q};
		dyw = {rd_y_q[31], rd_y_q} - {py_q[31], py_q};
		axw = dxw[32] ? 33'(-dxw) : 33'(dxw);
		ayw = dyw[32] ? 33'(-dyw) : 33'(dyw);
	end

	// walk decisions
	logic [64:0] wd;
	logic w_upd, w_last1, la_far, la_stop;
	logic [IDX_W-1:0] near_new, la_tgt;
	always_comb begin
		wd = {1'b0, sqa_q[63:0]} + {1'b0, sqb_q[63:0]};
		w_upd = (idx_q == '0) || (wd < best_q);
		near_new = w_upd ? idx_q[IDX_W-1:0] : near_q;
		w_last1 = idx_q == cnt - CNT_W'(1);
		la_far = wd >= {3'b000, l2_q};
		la_stop = la_far || ((idx_q + CNT_W'(1)) == cnt);
		if (!la_far) la_tgt = idx_q[IDX_W-1:0];
		else if (idx_q == '0) la_tgt = '0;
		else la_tgt = IDX_W'(idx_q - CNT_W'(1));
	end

	// shared multiplier
	logic [32:0] mul_a, mul_b, sq_x, sq_y;
	logic [65:0] mul_p;
	logic [31:0] emag;
	logic signed [32:0] de;
	logic [32:0] demag;
	always_comb begin
		emag = e_q[31] ? 32'(-e_q) : 32'(e_q);
		de = {e_q[31], e_q} - {prev_err_q[31], prev_err_q};
		demag = de[32] ? 33'(-de) : 33'(de);
		sq_x = (state_q == ST_DA && big_q) ? (ax_q >> 2) : ax_q;
		sq_y = (state_q == ST_DB && big_q) ? (ay_q >> 2) : ay_q;
		unique case (state_q)
			ST_L2: begin
				mul_a = {2'b00, look_q};
				mul_b = {2'b00, look_q};
			end
			ST_WSQA, ST_DA: begin
				mul_a = sq_x;
				mul_b = sq_x;
			end
			ST_WSQB, ST_DB: begin
				mul_a = sq_y;
				mul_b = sq_y;
			end
			ST_KP: begin
				mul_a = {1'b0, emag};
				mul_b = {2'b00, kp_q};
			end
			ST_KD: begin
				mul_a = demag;
				mul_b = {2'b00, kd_q};
			end
			ST_WBS: begin
				mul_a = {2'b00, wb_q};
				mul_b = smag_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// speed law terms
	logic [9:0] rate_eff;
	logic [10:0] trial;
	logic [57:0] t3mag;
	logic signed [33:0] qv;
	logic signed [61:0] vsum;
	logic signed [31:0] vsat;
	always_comb begin
		rate_eff = (rate_q == '0) ? 10'd1 : rate_q;
		trial = {rem_q, dq_q[31]};
		t3mag = p3mag_q * rate_eff;
		qv = e_q[31] ? -$signed({2'b00, dq_q}) : $signed({2'b00, dq_q});
		vsum = 62'(p1_q) + 62'(qv) + 62'(t3_q);
		if (vsum > 62'sd2147483647) vsat = 32'sh7FFF_FFFF;
		else if (vsum < -62'sd2147483648) vsat = 32'sh8000_0000;
		else vsat = 32'(vsum);
	end

	// cordic and square root units
	cor_cmd_t cor_cmd;
	logic signed [CW-1:0] cor_x0, cor_y0, cor_y;
	logic signed [ZW-1:0] cor_z0, cor_z;
	logic cor_done, sq_start, sq_done;
	logic [63:0] sq_rad;
	logic [31:0] sq_root;
	logic signed [33:0] vy1;
	logic signed [AW-1:0] a_fold;

	always_comb begin
		vy1 = dx_q[32] ? -34'(dy_q) : 34'(dy_q);
		if (alpha_q > ANG_PI_2) a_fold = ANG_PI - alpha_q;
		else if (alpha_q < -ANG_PI_2) a_fold = -ANG_PI - alpha_q;
		else a_fold = alpha_q;
		cor_cmd.start = 1'b0;
		cor_cmd.rotate = 1'b0;
		cor_x0 = '0;
		cor_y0 = '0;
		cor_z0 = '0;
		unique case (state_q)
			ST_V1GO: begin
				cor_cmd.start = 1'b1;
				cor_x0 = CW'($signed({1'b0, ax_q}));
				cor_y0 = CW'(vy1);
			end
			ST_SINGO: begin
				cor_cmd.start = 1'b1;
				cor_cmd.rotate = 1'b1;
				cor_x0 = CORDIC_GAIN;
				cor_z0 = ZW'(a_fold);
			end
			ST_V2GO: begin
				cor_cmd.start = 1'b1;
				cor_x0 = CW'($signed({1'b0, dist_q, 16'h0000}));
				cor_y0 = CW'(num_q);
			end
			default: ;
		endcase
		sq_start = state_q == ST_DS;
		sq_rad = sqa_q[63:0] + sqb_q[63:0];
	end

	ppsc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd),
		.x0     (cor_x0),
		.y0     (cor_y0),
		.z0     (cor_z0),
		.y      (cor_y),
		.z      (cor_z),
		.done   (cor_done)
	);

	ppsc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.root     (sq_root),
		.done     (sq_done)
	);

	// angle and steering arithmetic
	logic signed [AW-1:0] z1, a0, a1, a2, z2, st_r, lim_s;
	logic [CW-1:0] ymag;
	always_comb begin
		z1 = (dy_q == '0) ? '0 : AW'(cor_z);
		a0 = z1 - $signed({{7{head_q[14]}}, head_q, 4'h0});
		a1 = (a0 > ANG_PI_2) ? a0 - ANG_PI : a0;
		a2 = (a1 < -ANG_PI_2) ? a1 + ANG_PI : a1;
		ymag = cor_y[CW-1] ? CW'(-cor_y) : CW'(cor_y);
		z2 = (num_q == '0) ? '0 : AW'(cor_z);
		st_r = (z2 + AW'(8)) >>> 4;
		lim_s = $signed({13'h0000, lim_q});
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid && in_op == OP_STEP) state_d = end_path ? ST_FIN : ST_L2;
			ST_L2: state_d = ST_WRD;
			ST_WRD: state_d = ST_WDIF;
			ST_WDIF: state_d = ST_WSQA;
			ST_WSQA: state_d = ST_WSQB;
			ST_WSQB: state_d = ST_WCMP;
			ST_WCMP: state_d = (walk2_q && la_stop) ? ST_SRD : ST_WRD;
			ST_SRD: state_d = ST_SPD;
			ST_SPD: state_d = ST_TRD;
			ST_TRD: state_d = ST_TGT;
			ST_TGT: state_d = ST_KP;
			ST_KP: state_d = ST_KD;
			ST_KD: state_d = ST_KR;
			ST_KR: state_d = ST_DIV;
			ST_DIV: if (div_cnt_q == 5'(DIV_LAST)) state_d = ST_VEL;
			ST_VEL: state_d = ST_V1GO;
			ST_V1GO: state_d = ST_V1WT;
			ST_V1WT: if (cor_done) state_d = ST_ALPHA;
			ST_ALPHA: state_d = ST_DA;
			ST_DA: state_d = ST_DB;
			ST_DB: state_d = ST_DS;
			ST_DS: state_d = ST_SQWT;
			ST_SQWT: if (sq_done) state_d = ST_SINGO;
			ST_SINGO: state_d = ST_SINWT;
			ST_SINWT: if (cor_done) state_d = ST_WBS;
			ST_WBS: state_d = ST_V2GO;
			ST_V2GO: state_d = ST_V2WT;
			ST_V2WT: if (cor_done) state_d = ST_STEER;
			ST_STEER: state_d = ST_FIN;
			ST_FIN: if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = state_q == ST_IDLE;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_err_q <= '0;
			cur_tgt_q  <= '0;
			m_valid_q  <= 1'b0;
			walk2_q    <= 1'b0;
			idx_q      <= '0;
			div_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && (!m_valid_q || m_tready)) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					walk2_q <= 1'b0;
				end
				ST_WCMP: begin
					if (!walk2_q) begin
						if (w_last1) begin
							walk2_q <= 1'b1;
							idx_q   <= CNT_W'(near_new);
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else if (la_stop) begin
						cur_tgt_q <= la_tgt;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_KR: div_cnt_q <= '0;
				ST_DIV: div_cnt_q <= div_cnt_q + 5'd1;
				ST_VEL: prev_err_q <= e_q;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				addr_q   <= '0;
				px_q     <= in_pos_x;
				py_q     <= in_pos_y;
				spd_in_q <= in_speed;
				head_q   <= in_heading;
				vel_q    <= '0;
				st_q     <= '0;
				done_q   <= 1'b1;
			end
			ST_L2: begin
				l2_q   <= mul_p[61:0];
				done_q <= 1'b0;
			end
			ST_WDIF: begin
				ax_q <= axw;
				ay_q <= ayw;
			end
			ST_WSQA: sqa_q <= mul_p;
			ST_WSQB: sqb_q <= mul_p;
			ST_WCMP: begin
				if (!walk2_q) begin
					if (w_upd) best_q <= wd;
					near_q <= near_new;
					addr_q <= w_last1 ? near_new : IDX_W'(idx_q + CNT_W'(1));
				end else if (la_stop) begin
					addr_q <= near_q;
				end else begin
					addr_q <= IDX_W'(idx_q + CNT_W'(1));
				end
			end
			ST_SPD: begin
				if ($signed({rd_s_q[31], rd_s_q} - {2'b00, spd_in_q}) < -33'sd2147483648)
					e_q <= 32'sh8000_0000;
				else e_q <= 32'({rd_s_q[31], rd_s_q} - {2'b00, spd_in_q});
				addr_q <= cur_tgt_q;
			end
			ST_TGT: begin
				dx_q  <= dxw;
				dy_q  <= dyw;
				ax_q  <= axw;
				ay_q  <= ayw;
				big_q <= (axw[32:31] != 2'b00) || (ayw[32:31] != 2'b00);
			end
			ST_KP: p1_q <= e_q[31] ? -$signed({2'b00, mul_p[62:16]})
				: $signed({2'b00, mul_p[62:16]});
			ST_KD: begin
				p3mag_q  <= mul_p[63:16];
				de_neg_q <= de[32];
			end
			ST_KR: begin
				t3_q  <= de_neg_q ? -$signed({2'b00, t3mag}) : $signed({2'b00, t3mag});
				dq_q  <= emag;
				rem_q <= '0;
			end
			ST_DIV: begin
				if (trial >= {1'b0, rate_eff}) begin
					rem_q <= 10'(trial - {1'b0, rate_eff});
					dq_q  <= {dq_q[30:0], 1'b1};
				end else begin
					rem_q <= trial[9:0];
					dq_q  <= {dq_q[30:0], 1'b0};
				end
			end
			ST_VEL: vel_q <= vsat;
			ST_ALPHA: alpha_q <= a2;
			ST_DA: sqa_q <= mul_p;
			ST_DB: sqb_q <= mul_p;
			ST_SQWT: if (sq_done) dist_q <= big_q ? {sq_root, 2'b00} : {2'b00, sq_root};
			ST_SINWT: if (cor_done) begin
				smag_q  <= ymag[32:0];
				s_neg_q <= cor_y[CW-1];
			end
			ST_WBS: num_q <= s_neg_q ? -$signed({2'b00, mul_p[47:0], 1'b0})
				: $signed({2'b00, mul_p[47:0], 1'b0});
			ST_STEER: begin
				if (st_r > lim_s) st_q <= 14'(lim_s);
				else if (st_r < -lim_s) st_q <= 14'(-lim_s);
				else st_q <= 14'(st_r);
			end
			ST_FIN: if (!m_valid_q || m_tready) begin
				res_vel_q  <= vel_q;
				res_st_q   <= st_q;
				res_tgt_q  <= 10'(32'(cur_tgt_q));
				res_done_q <= done_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {res_tgt_q, res_st_q, res_vel_q};
	assign m_tuser  = res_done_q;

	// checks
	`PPSC_ASSERT_IMP(a_done_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[45:0] == 46'h0)
	`PPSC_ASSERT_NXT(a_fin_emits, clk, arst_n, (state_q == ST_FIN) && !m_tvalid, m_tvalid)
	`PPSC_ASSERT_IMP(a_steer_lim, clk, arst_n, m_tvalid, $signed(m_tdata[45:32]) <= lim_s)
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pure pursuit steering controller: a queue-fed
// stream driver, a stalling result monitor and a bit-exact path tracker model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	import ppsc_pkg::*;

	typedef struct {
		op_t                op;
		logic [9:0]         idx;
		logic signed [31:0] wx, wy, ws, px, py;
		logic [30:0]        spd;
		logic signed [14:0] hd;
	} track_item_t;

	typedef struct {
		logic signed [31:0] vel;
		logic signed [13:0] steer;
		logic [9:0]         tgt;
		logic               done;
	} command_t;

	localparam longint ANG_PI_Q = 205887;
	localparam longint ANG_PI_2_Q = 102944;
	localparam longint DIST_SAT = (64'd1 << 34) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pure_pursuit_steering_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	track_item_t pending_items[$];
	command_t expected_cmds[$];
	int errors = 0;

	// tracker model state and configuration
	longint path_x[1024], path_y[1024], path_v[1024];
	longint last_err;
	int unsigned cur_tgt;
	longint unsigned look_q, wb_q, rate_q, count_q, kp_q, kd_q, lim_q;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint gain_mul(longint a, longint unsigned g);
		longint unsigned p;
		p = (magnitude(a) * g) >> 16;
		return a < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned b, r;
		b = 64'd1 << 62;
		r = 0;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [65:0] range_sq(int i, longint px, longint py);
		longint unsigned a, b;
		a = magnitude(path_x[i] - px);
		b = magnitude(path_y[i] - py);
		return 66'(a) * 66'(a) + 66'(b) * 66'(b);
	endfunction

	function automatic longint arctan_vec(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		if (y == 0) return 0;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += longint'(atan_lut(4'(i)));
			end else begin
				x -= ys; y += xs; z -= longint'(atan_lut(4'(i)));
			end
		end
		return z;
	endfunction

	function automatic longint sine_q16(longint a);
		longint x, y, xs, ys;
		x = 39797;
		y = 0;
		if (a > ANG_PI_2_Q) a = ANG_PI_Q - a;
		else if (a < -ANG_PI_2_Q) a = -ANG_PI_Q - a;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (a >= 0) begin
				x -= ys; y += xs; a -= longint'(atan_lut(4'(i)));
			end else begin
				x += ys; y -= xs; a += longint'(atan_lut(4'(i)));
			end
		end
		return y;
	endfunction

	// register write into the model copy
	function automatic void model_config(cfg_reg_t r, logic [31:0] v);
		case (r)
			REG_LOOKAHEAD:   look_q = v[30:0];
			REG_WHEEL_BASE:  wb_q = v[30:0];
			REG_RATE:        rate_q = v[9:0];
			REG_COUNT:       count_q = v[10:0];
			REG_KP:          kp_q = v[30:0];
			REG_KD:          kd_q = v[30:0];
			REG_STEER_LIMIT: lim_q = v[12:0];
			default: ;
		endcase
	endfunction

	// one accepted transaction: update table or compute the commands
	function automatic void track_step(track_item_t it);
		command_t c;
		int unsigned cnt, nearest, j;
		logic [65:0] best, d, l2;
		longint px, py, e, vel, dx, dy, alpha, s, st, rate;
		longint unsigned ax, ay, span_len;
		if (it.op == OP_LOAD) begin
			path_x[it.idx] = it.wx;
			path_y[it.idx] = it.wy;
			path_v[it.idx] = it.ws;
			return;
		end
		cnt = count_q > 1024 ? 1024 : int'(count_q);
		if (cnt <= 1 || cur_tgt >= cnt - 1) begin
			c.vel = 0; c.steer = 0; c.tgt = cur_tgt[9:0]; c.done = 1'b1;
			expected_cmds.insert(expected_cmds.size(), c);
			return;
		end
		px = it.px;
		py = it.py;
		nearest = 0;
		best = '0;
		for (int i = 0; i < cnt; i++) begin
			d = range_sq(i, px, py);
			if (i == 0 || d < best) begin
				best = d;
				nearest = i;
			end
		end
		l2 = 66'(look_q * look_q);
		j = nearest;
		while (j < cnt && range_sq(j, px, py) < l2) j++;
		cur_tgt = j == 0 ? 0 : j - 1;

		// speed law
		rate = rate_q == 0 ? 1 : longint'(rate_q);
		e = clip32(path_v[nearest] - longint'(it.spd));
		vel = gain_mul(e, kp_q) + e / rate + gain_mul(e - last_err, kd_q) * rate;
		last_err = e;
		vel = clip32(vel);

		// steering law
		dx = path_x[cur_tgt] - px;
		dy = path_y[cur_tgt] - py;
		alpha = arctan_vec(longint'(magnitude(dx)), dx < 0 ? -dy : dy)
			- longint'(it.hd) * 16;
		if (alpha > ANG_PI_2_Q) alpha -= ANG_PI_Q;
		if (alpha < -ANG_PI_2_Q) alpha += ANG_PI_Q;
		ax = magnitude(dx);
		ay = magnitude(dy);
		if (ax < (64'd1 << 31) && ay < (64'd1 << 31)) span_len = int_root(ax * ax + ay * ay);
		else span_len = int_root((ax >> 2) * (ax >> 2) + (ay >> 2) * (ay >> 2)) << 2;
		if (span_len > DIST_SAT) span_len = DIST_SAT;
		s = sine_q16(alpha);
		st = arctan_vec(longint'(span_len << 16), 2 * longint'(wb_q) * s);
		st = (st + 8) >>> 4;
		if (st > longint'(lim_q)) st = longint'(lim_q);
		if (st < -longint'(lim_q)) st = -longint'(lim_q);
		c.vel = vel[31:0];
		c.steer = st[13:0];
		c.tgt = cur_tgt[9:0];
		c.done = 1'b0;
		expected_cmds.insert(expected_cmds.size(), c);
	endfunction

	// input driver: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin : drive_proc
		logic nv;
		track_item_t it, acc;
		nv = s_tvalid;
		if (s_tvalid && s_tready) begin
			acc.op = op_t'(s_tuser[0]);
			{acc.hd, acc.spd, acc.py, acc.px, acc.ws, acc.wy, acc.wx, acc.idx} = s_tdata;
			track_step(acc);
			nv = 1'b0;
		end
		if (!nv && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				s_tdata <= {it.hd, it.spd, it.py, it.px, it.ws, it.wy, it.wx, it.idx};
				s_tuser <= it.op;
				nv = 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left--;
				end
			end
		end
		s_tvalid <= nv;
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result monitor with its own stall pattern
	int cyc = 0;
	int stall_mode = 0;
	always @(posedge clk) begin : monitor_proc
		command_t w;
		logic signed [31:0] gv;
		logic signed [13:0] gs;
		cyc++;
		if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cyc % 8) < 5);
		endcase
		if (m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				w = expected_cmds.pop_front();
				gv = m_tdata[31:0];
				gs = m_tdata[45:32];
				if (gv != w.vel) report("velocity_cmd", gv, w.vel);
				if (gs != w.steer) report("steering_cmd", gs, w.steer);
				if (m_tdata[55:46] != w.tgt) report("target_index", m_tdata[55:46], w.tgt);
				if (m_tuser[0] != w.done) report("done_res", m_tuser[0], w.done);
			end
		end
	end

	task automatic add_load(int idx, longint x, longint y, longint v);
		track_item_t it;
		it = '{OP_LOAD, 10'(idx), 32'(x), 32'(y), 32'(v), 32'($urandom), 32'($urandom),
			31'($urandom), 15'($urandom)};
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_step(longint px, longint py, longint spd, int hd);
		track_item_t it;
		it = '{OP_STEP, 10'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
			32'(px), 32'(py), 31'(spd), 15'(hd)};
		pending_items.insert(pending_items.size(), it);
	endtask

	// settled values are checked away from the driving edge
	task automatic wait_idle();
		while (pending_items.size() > 0 || s_tvalid || expected_cmds.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, longint v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= 32'(v);
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		model_config(r, 32'(v));
		cfg_valid <= 1'b0;
	endtask

	function automatic longint pick_ext(longint lo, longint hi, longint typ);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return typ;
		endcase
	endfunction

	function automatic int rand_heading();
		return $urandom_range(0, 25736) - 12868;
	endfunction

	// stimulus sequence
	initial begin : stim_proc
		int n, k, spacing;
		longint x0, y0, px, py;
		longint wxs[32], wys[32];
		last_err = 0;
		cur_tgt = 0;
		look_q = 6554; wb_q = 2621; rate_q = 10; count_q = 0;
		kp_q = 65536; kd_q = 0; lim_q = 2048;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty path and single waypoint path end at once
		add_step(0, 0, 0, 0);
		wait_idle();
		write_reg(REG_COUNT, 1);
		add_step(65536, -65536, 100, 12868);
		wait_idle();

		// directed: ties, zero distance, vertical line, huge offsets
		write_reg(REG_COUNT, 4);
		write_reg(REG_LOOKAHEAD, 0);
		write_reg(REG_STEER_LIMIT, 6434);
		add_load(0, 0, 0, 64'sd2147483647);
		add_load(1, 65536, 0, -64'sd2147483648);
		add_load(2, 65536, 0, 0);
		add_load(3, 64'sd2147483647, -64'sd2147483648, 65536);
		add_step(0, 0, 0, 0);
		add_step(0, 0, 64'd2147483647, -12868);
		add_step(65536, 131072, 65536, 12868);
		add_step(65536, 0, 0, 0);
		add_step(-64'sd2147483648, 64'sd2147483647, 0, 12868);
		wait_idle();
		write_reg(REG_LOOKAHEAD, 64'd2147483647);
		write_reg(REG_WHEEL_BASE, 64'd2147483647);
		write_reg(REG_KP, 64'd2147483647);
		write_reg(REG_KD, 64'd2147483647);
		write_reg(REG_RATE, 0);
		add_step(0, -64'sd2147483648, 64'd2147483647, -12868);
		add_step(1, 0, 0, 1);
		wait_idle();
		write_reg(REG_STEER_LIMIT, 8191);
		write_reg(REG_RATE, 1023);
		write_reg(REG_LOOKAHEAD, 100000);
		add_step(40000, 70000, 3000, -100);
		add_step(64'sd2147483647, 64'sd2147483647, 5, 4000);
		wait_idle();

		// random phases: well-formed paths driven along, with some noise
		for (int ph = 0; ph < 7; ph++) begin
			n = $urandom_range(2, 24);
			spacing = $urandom_range(1 << 14, 1 << 18);
			x0 = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
			y0 = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
			write_reg(REG_COUNT, pick_ext(0, 1, n));
			write_reg(REG_LOOKAHEAD, pick_ext(0, 64'd2147483647,
				$urandom_range(spacing / 2, spacing * 4)));
			write_reg(REG_WHEEL_BASE, pick_ext(0, 64'd2147483647, $urandom_range(1, 1 << 18)));
			write_reg(REG_RATE, pick_ext(0, 1023, $urandom_range(1, 1000)));
			write_reg(REG_KP, pick_ext(0, 64'd2147483647, $urandom_range(0, 1 << 18)));
			write_reg(REG_KD, pick_ext(0, 64'd2147483647, $urandom_range(0, 1 << 17)));
			write_reg(REG_STEER_LIMIT, pick_ext(0, 8191, $urandom_range(0, 6434)));
			for (int i = 0; i < n; i++) begin
				wxs[i] = x0 + longint'(i) * spacing;
				wys[i] = y0 + longint'($urandom_range(0, spacing)) - spacing / 2;
				add_load(i, wxs[i], wys[i], longint'($urandom_range(0, 8 << 16)) - (4 << 16));
			end
			for (int t = 0; t < 22; t++) begin
				k = $urandom_range(0, n - 1);
				case ($urandom_range(0, 9))
					0: add_step(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
						$urandom & 32'h7fffffff, rand_heading());
					1: add_load($urandom_range(n, 1023), longint'(signed'(32'($urandom))),
						longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))));
					default: begin
						px = wxs[k] + longint'($urandom_range(0, 2 * spacing)) - spacing;
						py = wys[k] + longint'($urandom_range(0, 2 * spacing)) - spacing;
						add_step(px, py, $urandom_range(0, 6 << 16), rand_heading());
					end
				endcase
			end
			wait_idle();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && expected_cmds.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ppsc_pkg.sv
rtl/core/ppsc_cordic.sv
rtl/core/ppsc_isqrt.sv
rtl/core/pure_pursuit_steering_controller_unit.sv
verif/tb_top.sv
